/* sv/dwm_pkg.sv */
// ----------------------------------------------------------------------------
// dwm_pkg: shared types and constants for the watch mode controller
// Transaction payloads, decoded command kinds, mode and adjust codes, and
// the calendar constants used by the time-of-day and stopwatch counters.
// ----------------------------------------------------------------------------
package dwm_pkg;

   localparam int DAY_SECOND_WIDTH   = 17;
   localparam int SECONDS_PER_MINUTE = 60;
   localparam int MINUTES_PER_HOUR   = 60;
   localparam int HOURS_PER_DAY      = 24;
   localparam int SECONDS_PER_DAY    = 86400;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [DAY_SECOND_WIDTH-1:0] LAST_SECOND_OF_DAY =
      DAY_SECOND_WIDTH'(SECONDS_PER_DAY - 1);

   // Input opcode and button numbers.
   localparam logic       OP_TICK      = 1'b0;
   localparam logic       OP_PRESS     = 1'b1;
   localparam logic [2:0] BUTTON_MODE  = 3'd1;
   localparam logic [2:0] BUTTON_START = 3'd2;
   localparam logic [2:0] BUTTON_LAP   = 3'd3;
   localparam logic [2:0] BUTTON_LIGHT = 3'd4;

   typedef enum logic [2:0] {
      MODE_TIME      = 3'd1,
      MODE_STOPWATCH = 3'd2,
      MODE_SET_ALARM = 3'd3,
      MODE_SET_TIME  = 3'd4,
      MODE_ALARMING  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      ADJ_NONE    = 2'd0,
      ADJ_HOURS   = 2'd1,
      ADJ_MINUTES = 2'd2
   } adjust_type;

   // Command kinds produced by the front end.
   typedef enum logic [2:0] {
      CMD_TICK    = 3'd0,
      CMD_BUTTON1 = 3'd1,
      CMD_BUTTON2 = 3'd2,
      CMD_BUTTON3 = 3'd3,
      CMD_INVERT  = 3'd4,
      CMD_IGNORE  = 3'd5
   } cmd_type;

   typedef struct packed {
      logic       opcode;
      logic [2:0] button_number;
   } req_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [4:0] time_hours;
      logic [5:0] time_minutes;
      logic [5:0] time_seconds;
      logic [4:0] lap_hours;
      logic [5:0] lap_minutes;
      logic [5:0] lap_seconds;
      logic       stopwatch_running;
      logic       lap_hold;
      logic       alarm_enabled;
      logic [1:0] alarm_adjust_step;
      logic       display_inverted;
   } rsp_type;

endpackage

/* sv/dwm_front.sv */
// ----------------------------------------------------------------------------
// dwm_front: request classifier
// Decodes each incoming transaction into a command kind and pushes it into
// the command queue. Presses of unknown buttons become no-op commands.
// ----------------------------------------------------------------------------
module dwm_front (
   input  logic             req_valid,
   output logic             req_ready,
   input  dwm_pkg::req_type req_data,
   output logic             push_valid,
   input  logic             push_ready,
   output dwm_pkg::cmd_type push_cmd
);

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

   always_comb begin
      if (req_data.opcode == dwm_pkg::OP_TICK) begin
         push_cmd = dwm_pkg::CMD_TICK;
      end else begin
         unique case (req_data.button_number)
            dwm_pkg::BUTTON_MODE:  push_cmd = dwm_pkg::CMD_BUTTON1;
            dwm_pkg::BUTTON_START: push_cmd = dwm_pkg::CMD_BUTTON2;
            dwm_pkg::BUTTON_LAP:   push_cmd = dwm_pkg::CMD_BUTTON3;
            dwm_pkg::BUTTON_LIGHT: push_cmd = dwm_pkg::CMD_INVERT;
            default:               push_cmd = dwm_pkg::CMD_IGNORE;
         endcase
      end
   end

endmodule

/* sv/dwm_cmd_queue.sv */
// ----------------------------------------------------------------------------
// dwm_cmd_queue: command queue
// Small FIFO between the classifier and the executor. Push and pop may
// happen in the same cycle. Depth must be at least 2.
// ----------------------------------------------------------------------------
module dwm_cmd_queue #(
   parameter int Depth = dwm_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  dwm_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output dwm_pkg::cmd_type pop_cmd
);

   localparam int PtrWidth   = $clog2(Depth);
   localparam int CountWidth = $clog2(Depth + 1);

   localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

   dwm_pkg::cmd_type        slot_ff [Depth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    push_fire, pop_fire;

   assign push_ready = (count_ff != FullCount);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* sv/dwm_back.sv */
// ----------------------------------------------------------------------------
// dwm_back: command executor
// Holds the watch state, carries out one command per cycle unless a held
// response stalls it, and registers the resulting display as the response.
// ----------------------------------------------------------------------------
module dwm_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [dwm_pkg::DAY_SECOND_WIDTH-1:0]   alarm_second,
   input  logic                                   pop_valid,
   output logic                                   pop_ready,
   input  dwm_pkg::cmd_type                       pop_cmd,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output dwm_pkg::rsp_type                       rsp_data
);

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } hms_type;

   // Advances a clock reading by one second, wrapping after 23:59:59.
   function automatic hms_type hms_step(hms_type t);
      hms_type r;
      r = t;
      if (t.seconds == 6'(dwm_pkg::SECONDS_PER_MINUTE - 1)) begin
         r.seconds = '0;
         if (t.minutes == 6'(dwm_pkg::MINUTES_PER_HOUR - 1)) begin
            r.minutes = '0;
            if (t.hours == 5'(dwm_pkg::HOURS_PER_DAY - 1)) begin
               r.hours = '0;
            end else begin
               r.hours = t.hours + 1'b1;
            end
         end else begin
            r.minutes = t.minutes + 1'b1;
         end
      end else begin
         r.seconds = t.seconds + 1'b1;
      end
      return r;
   endfunction

   logic [dwm_pkg::DAY_SECOND_WIDTH-1:0] day_ff, day_in;
   hms_type              time_ff, time_in;
   hms_type              sw_ff, sw_in;
   hms_type              shown_ff, shown_in;
   dwm_pkg::mode_type    mode_ff, mode_in;
   dwm_pkg::mode_type    pending_ff, pending_in;
   dwm_pkg::adjust_type  adjust_ff, adjust_in;
   logic                 running_ff, running_in;
   logic                 hold_ff, hold_in;
   logic                 enable_ff, enable_in;
   logic                 armed_ff, armed_in;
   logic                 sounding_ff, sounding_in;
   logic                 invert_ff, invert_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   dwm_pkg::rsp_type     rsp_data_ff, rsp_data_in;
   logic                 fire;
   logic                 is_b2, is_b3;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = pop_valid && pop_ready;
   assign is_b2     = (pop_cmd == dwm_pkg::CMD_BUTTON2);
   assign is_b3     = (pop_cmd == dwm_pkg::CMD_BUTTON3);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      day_in      = day_ff;
      time_in     = time_ff;
      sw_in       = sw_ff;
      shown_in    = shown_ff;
      mode_in     = mode_ff;
      pending_in  = pending_ff;
      adjust_in   = adjust_ff;
      running_in  = running_ff;
      hold_in     = hold_ff;
      enable_in   = enable_ff;
      armed_in    = armed_ff;
      sounding_in = sounding_ff;
      invert_in   = invert_ff;

      if (fire) begin
         unique case (pop_cmd)
            dwm_pkg::CMD_TICK: begin
               time_in = hms_step(time_ff);
               // Midnight re-arms the alarm before the firing check.
               if (day_ff == dwm_pkg::LAST_SECOND_OF_DAY) begin
                  day_in   = '0;
                  armed_in = enable_ff;
               end else begin
                  day_in = day_ff + 1'b1;
               end
               if (armed_in && (day_in == alarm_second)) begin
                  armed_in    = 1'b0;
                  sounding_in = 1'b1;
                  mode_in     = dwm_pkg::MODE_ALARMING;
               end
               if (running_ff) begin
                  sw_in = hms_step(sw_ff);
                  if (!hold_ff) begin
                     shown_in = sw_in;
                  end
               end
            end
            dwm_pkg::CMD_INVERT: begin
               invert_in = !invert_ff;
            end
            dwm_pkg::CMD_BUTTON1, dwm_pkg::CMD_BUTTON2, dwm_pkg::CMD_BUTTON3: begin
               if (sounding_ff) begin
                  // Any of the first three buttons only silences the alarm and returns to time mode.
                  sounding_in = 1'b0;
                  armed_in    = enable_ff;
                  pending_in  = dwm_pkg::MODE_TIME;
                  mode_in     = dwm_pkg::MODE_TIME;
               end else begin
                  if (pop_cmd == dwm_pkg::CMD_BUTTON1) begin
                     if (pending_ff == dwm_pkg::MODE_SET_TIME) begin
                        pending_in = dwm_pkg::MODE_TIME;
                     end else begin
                        pending_in = dwm_pkg::mode_type'(pending_ff + 3'd1);
                     end
                  end
                  mode_in = pending_in;
                  if (pending_in == dwm_pkg::MODE_STOPWATCH) begin
                     if (is_b2) begin
                        running_in = !running_ff;
                     end else if (is_b3) begin
                        if (running_ff) begin
                           hold_in = !hold_ff;
                        end else begin
                           sw_in    = '0;
                           shown_in = '0;
                        end
                     end
                  end else if (pending_in == dwm_pkg::MODE_SET_ALARM) begin
                     priority if (adjust_ff == dwm_pkg::ADJ_NONE && is_b2) begin
                        enable_in = !enable_ff;
                        armed_in  = !enable_ff;
                     end else if ((adjust_ff == dwm_pkg::ADJ_NONE && is_b3) ||
                                  (adjust_ff == dwm_pkg::ADJ_MINUTES && is_b2)) begin
                        adjust_in = dwm_pkg::ADJ_HOURS;
                     end else if (adjust_ff == dwm_pkg::ADJ_HOURS && is_b2) begin
                        adjust_in = dwm_pkg::ADJ_MINUTES;
                     end else if (adjust_ff != dwm_pkg::ADJ_NONE && is_b3) begin
                        adjust_in = dwm_pkg::ADJ_NONE;
                     end else begin
                        adjust_in = adjust_ff;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      rsp_data_in.mode              = mode_in;
      rsp_data_in.time_hours        = time_in.hours;
      rsp_data_in.time_minutes      = time_in.minutes;
      rsp_data_in.time_seconds      = time_in.seconds;
      rsp_data_in.lap_hours         = shown_in.hours;
      rsp_data_in.lap_minutes       = shown_in.minutes;
      rsp_data_in.lap_seconds       = shown_in.seconds;
      rsp_data_in.stopwatch_running = running_in;
      rsp_data_in.lap_hold          = hold_in;
      rsp_data_in.alarm_enabled     = enable_in;
      rsp_data_in.alarm_adjust_step = adjust_in;
      rsp_data_in.display_inverted  = invert_in;

      rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff       <= '0;
         time_ff      <= '0;
         sw_ff        <= '0;
         shown_ff     <= '0;
         mode_ff      <= dwm_pkg::MODE_TIME;
         pending_ff   <= dwm_pkg::MODE_TIME;
         adjust_ff    <= dwm_pkg::ADJ_NONE;
         running_ff   <= 1'b0;
         hold_ff      <= 1'b0;
         enable_ff    <= 1'b0;
         armed_ff     <= 1'b0;
         sounding_ff  <= 1'b0;
         invert_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         day_ff       <= day_in;
         time_ff      <= time_in;
         sw_ff        <= sw_in;
         shown_ff     <= shown_in;
         mode_ff      <= mode_in;
         pending_ff   <= pending_in;
         adjust_ff    <= adjust_in;
         running_ff   <= running_in;
         hold_ff      <= hold_in;
         enable_ff    <= enable_in;
         armed_ff     <= armed_in;
         sounding_ff  <= sounding_in;
         invert_ff    <= invert_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* sv/digital_watch_mode_controller.sv */
// ----------------------------------------------------------------------------
// digital_watch_mode_controller: watch with time of day, stopwatch and alarm
// Ticks and button presses are classified, queued and executed in order;
// each request transaction yields one response with the updated display.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_valid/req_ready    dwm_pkg::req_type
//   rsp_      out         rsp_valid/rsp_ready    dwm_pkg::rsp_type
//   csr_      in          csr_valid/csr_ready    alarm second of day, 17 bits
//
// One transaction per cycle is sustained while rsp_ready stays high; each
// accepted request is written into the command queue and is then executed
// into the output register, which presents its response. Reset is
// synchronous. While a response is held, the queue takes up to
// QueueDepth further requests before req_ready drops.
// ----------------------------------------------------------------------------
module digital_watch_mode_controller #(
   parameter int QueueDepth = dwm_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  dwm_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output dwm_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dwm_pkg::DAY_SECOND_WIDTH-1:0] csr_data
);

   logic [dwm_pkg::DAY_SECOND_WIDTH-1:0] alarm_ff;
   logic                                 push_valid, push_ready;
   dwm_pkg::cmd_type                     push_cmd;
   logic                                 pop_valid, pop_ready;
   dwm_pkg::cmd_type                     pop_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         alarm_ff <= csr_data;
      end
   end

   dwm_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   dwm_cmd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   dwm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .alarm_second (alarm_ff),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_cmd      (pop_cmd),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   // A response always reports one of the five defined modes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.mode >= 3'd1 && rsp_data.mode <= 3'd5))
      else $error("response mode out of range");

   // The time-of-day and lap readings are always valid clock readings.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.time_hours < 5'd24 && rsp_data.time_minutes < 6'd60 &&
                     rsp_data.time_seconds < 6'd60 && rsp_data.lap_hours < 5'd24 &&
                     rsp_data.lap_minutes < 6'd60 && rsp_data.lap_seconds < 6'd60))
      else $error("clock reading out of range");

   // The alarm adjust step never reaches the unused code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.alarm_adjust_step != 2'd3))
      else $error("alarm adjust step out of range");

   // A queued command is taken whenever the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      (pop_valid && !rsp_valid) |=> rsp_valid)
      else $error("queued command not executed");

endmodule

/* tb/watch_display_checker.sv */
// ----------------------------------------------------------------------------
// watch_display_checker: predicts and checks the watch display
// Follows every accepted request and alarm-register transaction with a
// private model of the watch. Each accepted response is compared field by
// field with the oldest predicted display.
// ----------------------------------------------------------------------------
module watch_display_checker
   import dwm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  req_type                     req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  rsp_type                     rsp_data,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [DAY_SECOND_WIDTH-1:0] csr_data,
   output int                          outstanding,
   output int                          mismatch_count
);

   localparam int SECONDS_PER_HOUR = SECONDS_PER_MINUTE * MINUTES_PER_HOUR;

   logic [DAY_SECOND_WIDTH-1:0] alarm_second;
   logic [DAY_SECOND_WIDTH-1:0] day_second;
   logic [DAY_SECOND_WIDTH-1:0] lap_count;
   logic [4:0]                  shown_hours;
   logic [5:0]                  shown_minutes;
   logic [5:0]                  shown_seconds;
   mode_type                    shown_mode;
   mode_type                    selected_mode;
   adjust_type                  adjust;
   logic                        running;
   logic                        holding;
   logic                        alarm_on;
   logic                        alarm_armed;
   logic                        ringing;
   logic                        inverted;

   rsp_type expected_displays[$];
   int      errors = 0;

   function void clear_watch();
      alarm_second  = '0;
      day_second    = '0;
      lap_count     = '0;
      shown_hours   = '0;
      shown_minutes = '0;
      shown_seconds = '0;
      shown_mode    = MODE_TIME;
      selected_mode = MODE_TIME;
      adjust        = ADJ_NONE;
      running       = 1'b0;
      holding       = 1'b0;
      alarm_on      = 1'b0;
      alarm_armed   = 1'b0;
      ringing       = 1'b0;
      inverted      = 1'b0;
   endfunction

   function void tick_watch();
      int unsigned next_second;
      int unsigned next_lap;
      next_second = day_second + 1;
      // The alarm re-arms from the enable each time the day rolls over.
      if (next_second > LAST_SECOND_OF_DAY) begin
         next_second = next_second - SECONDS_PER_DAY;
         alarm_armed = alarm_on;
      end
      day_second = DAY_SECOND_WIDTH'(next_second);
      if (alarm_armed && day_second == alarm_second) begin
         alarm_armed = 1'b0;
         ringing     = 1'b1;
         shown_mode  = MODE_ALARMING;
      end
      if (running) begin
         next_lap = lap_count + 1;
         if (next_lap > LAST_SECOND_OF_DAY)
            next_lap = next_lap - SECONDS_PER_DAY;
         lap_count = DAY_SECOND_WIDTH'(next_lap);
         if (!holding) begin
            shown_seconds = 6'(next_lap % SECONDS_PER_MINUTE);
            shown_minutes = 6'((next_lap / SECONDS_PER_MINUTE) % MINUTES_PER_HOUR);
            shown_hours   = 5'((next_lap / SECONDS_PER_HOUR) % HOURS_PER_DAY);
         end
      end
   endfunction

   function void press_watch(logic [2:0] button);
      if (button == BUTTON_LIGHT) begin
         inverted = !inverted;
         return;
      end
      if (button < BUTTON_MODE || button > BUTTON_LAP)
         return;
      // Any of the first three buttons only silences a sounding alarm and returns to time mode.
      if (ringing) begin
         ringing       = 1'b0;
         alarm_armed   = alarm_on;
         selected_mode = MODE_TIME;
         shown_mode    = MODE_TIME;
         return;
      end
      if (button == BUTTON_MODE) begin
         if (selected_mode == MODE_SET_TIME)
            selected_mode = MODE_TIME;
         else
            selected_mode = mode_type'(selected_mode + 1);
      end
      shown_mode = selected_mode;
      case (shown_mode)
         MODE_STOPWATCH: begin
            if (button == BUTTON_START) begin
               running = !running;
            end else if (button == BUTTON_LAP) begin
               if (running) begin
                  holding = !holding;
               end else begin
                  lap_count     = '0;
                  shown_hours   = '0;
                  shown_minutes = '0;
                  shown_seconds = '0;
               end
            end
         end
         MODE_SET_ALARM: begin
            if (adjust == ADJ_NONE && button == BUTTON_START) begin
               alarm_on    = !alarm_on;
               alarm_armed = !alarm_armed || alarm_on ? alarm_on : alarm_on;
            end else if ((adjust == ADJ_NONE && button == BUTTON_LAP) ||
                         (adjust == ADJ_MINUTES && button == BUTTON_START)) begin
               adjust = ADJ_HOURS;
            end else if (adjust == ADJ_HOURS && button == BUTTON_START) begin
               adjust = ADJ_MINUTES;
            end else if (adjust != ADJ_NONE && button == BUTTON_LAP) begin
               adjust = ADJ_NONE;
            end
         end
         default: begin
         end
      endcase
   endfunction

   function rsp_type watch_display();
      rsp_type shown;
      shown.mode              = shown_mode;
      shown.time_hours        = 5'((day_second / SECONDS_PER_HOUR) % HOURS_PER_DAY);
      shown.time_minutes      = 6'((day_second / SECONDS_PER_MINUTE) % MINUTES_PER_HOUR);
      shown.time_seconds      = 6'(day_second % SECONDS_PER_MINUTE);
      shown.lap_hours         = shown_hours;
      shown.lap_minutes       = shown_minutes;
      shown.lap_seconds       = shown_seconds;
      shown.stopwatch_running = running;
      shown.lap_hold          = holding;
      shown.alarm_enabled     = alarm_on;
      shown.alarm_adjust_step = adjust;
      shown.display_inverted  = inverted;
      return shown;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("display field %s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   task automatic compare_display(rsp_type want, rsp_type got);
      check_field("mode", want.mode, got.mode);
      check_field("time_hours", want.time_hours, got.time_hours);
      check_field("time_minutes", want.time_minutes, got.time_minutes);
      check_field("time_seconds", want.time_seconds, got.time_seconds);
      check_field("lap_hours", want.lap_hours, got.lap_hours);
      check_field("lap_minutes", want.lap_minutes, got.lap_minutes);
      check_field("lap_seconds", want.lap_seconds, got.lap_seconds);
      check_field("stopwatch_running", want.stopwatch_running, got.stopwatch_running);
      check_field("lap_hold", want.lap_hold, got.lap_hold);
      check_field("alarm_enabled", want.alarm_enabled, got.alarm_enabled);
      check_field("alarm_adjust_step", want.alarm_adjust_step, got.alarm_adjust_step);
      check_field("display_inverted", want.display_inverted, got.display_inverted);
   endtask

   // A request is predicted before a response is retired in the same cycle,
   // so a block with a shorter latency than expected is still judged fairly.
   always @(posedge clock) begin
      if (reset) begin
         clear_watch();
         expected_displays.delete();
      end else begin
         if (csr_valid && csr_ready)
            alarm_second = csr_data;
         if (req_valid && req_ready) begin
            if (req_data.opcode == OP_TICK)
               tick_watch();
            else
               press_watch(req_data.button_number);
            expected_displays.push_back(watch_display());
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_displays.size() == 0) begin
               $error("response transaction with no request outstanding");
               errors++;
            end else begin
               compare_display(expected_displays.pop_front(), rsp_data);
            end
         end
      end
      outstanding    <= expected_displays.size();
      mismatch_count <= errors;
   end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench for the watch mode controller
// Drives ticks, button presses and alarm settings through the handshake
// channels with random bursts and stalls, ends with the stopwatch running
// into an armed alarm, and reports the verdict from the display checker.
// ----------------------------------------------------------------------------
module tb_top;
   import dwm_pkg::*;

   localparam int          CYCLE_LIMIT   = 4_000_000;
   localparam int          PHASE_COUNT   = 6;
   localparam int          PHASE_ITEMS   = 140;
   localparam int          FINAL_TICKS   = 60;
   localparam int          DIRECTED_ALARM = 12;
   localparam logic [2:0]  BUTTON_NONE   = 3'd0;
   localparam logic [2:0]  BUTTON_LAST   = 3'd7;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   req_type                     req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   rsp_type                     rsp_data;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [DAY_SECOND_WIDTH-1:0] csr_data = '0;

   int          outstanding;
   int          mismatch_count;
   rsp_type     last_display = '0;
   int unsigned ticks_sent = 0;
   int unsigned burst_left = 0;
   int unsigned long_holds = 0;
   logic        random_phase = 1'b0;

   digital_watch_mode_controller u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   watch_display_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .outstanding    (outstanding),
      .mismatch_count (mismatch_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // The stimulus steers the watch into known modes from what it last showed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         last_display <= rsp_data;
   end

   // Response side: free-running and stalling stretches, plus long hold-offs
   // during the random phases so that the block backs up into its input.
   initial begin
      int unsigned span;
      logic        stalling;
      @(posedge clock);
      forever begin
         if (random_phase && (long_holds == 0 || $urandom_range(9) == 0)) begin
            long_holds++;
            span = $urandom_range(30, 90);
            repeat (span) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end
         span     = $urandom_range(10, 120);
         stalling = $urandom_range(2) != 0;
         repeat (span) begin
            rsp_ready <= stalling ? ($urandom_range(3) != 0) : 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic req_type make_item(logic opcode, logic [2:0] button);
      req_type item;
      item.opcode        = opcode;
      item.button_number = button;
      return item;
   endfunction

   function automatic req_type random_item();
      int unsigned pick;
      logic [2:0]  invalid;
      pick    = $urandom_range(99);
      invalid = ($urandom_range(3) == 0) ? BUTTON_NONE
                : 3'($urandom_range(BUTTON_LIGHT + 1, BUTTON_LAST));
      if (pick < 45)
         return make_item(OP_TICK, 3'($urandom_range(BUTTON_LAST)));
      else if (pick < 53)
         return make_item(OP_PRESS, BUTTON_MODE);
      else if (pick < 70)
         return make_item(OP_PRESS, BUTTON_START);
      else if (pick < 85)
         return make_item(OP_PRESS, BUTTON_LAP);
      else if (pick < 93)
         return make_item(OP_PRESS, BUTTON_LIGHT);
      else
         return make_item(OP_PRESS, invalid);
   endfunction

   // Holds the transaction until it is taken; valid stays up for the next one.
   task automatic offer(req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (item.opcode == OP_TICK)
         ticks_sent++;
   endtask

   task automatic send(req_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 120)
                      : $urandom_range(1, 16);
      end
      burst_left--;
      offer(item);
   endtask

   task automatic tick();
      send(make_item(OP_TICK, 3'($urandom_range(BUTTON_LAST))));
   endtask

   task automatic press(logic [2:0] button);
      send(make_item(OP_PRESS, button));
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_alarm(logic [DAY_SECOND_WIDTH-1:0] second);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= second;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic press_until_mode(mode_type target);
      settle();
      while (last_display.mode != target) begin
         press(BUTTON_MODE);
         settle();
      end
   endtask

   function automatic logic [DAY_SECOND_WIDTH-1:0] alarm_soon();
      return DAY_SECOND_WIDTH'((ticks_sent % SECONDS_PER_DAY) + $urandom_range(1, 40));
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: ignored buttons, inversion, stopwatch, alarm setup and firing.
      write_alarm(DAY_SECOND_WIDTH'(DIRECTED_ALARM));
      tick();
      press(BUTTON_NONE);
      press(BUTTON_LIGHT + 1);
      press(BUTTON_LAST);
      press(BUTTON_LIGHT);
      press(BUTTON_LIGHT);
      press(BUTTON_MODE);
      press(BUTTON_LAP);
      press(BUTTON_START);
      tick();
      press(BUTTON_LAP);
      tick();
      press(BUTTON_LAP);
      tick();
      press(BUTTON_START);
      press(BUTTON_LAP);
      press(BUTTON_MODE);
      press(BUTTON_START);
      press(BUTTON_LAP);
      press(BUTTON_START);
      press(BUTTON_START);
      press(BUTTON_LAP);
      press(BUTTON_MODE);
      press(BUTTON_START);
      press(BUTTON_LAP);
      press(BUTTON_MODE);
      while (ticks_sent < DIRECTED_ALARM + 2)
         tick();
      press(BUTTON_LIGHT);
      press(BUTTON_START);

      // Random phases, each with its own alarm setting.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            1:       write_alarm(LAST_SECOND_OF_DAY);
            2:       write_alarm('1);
            3:       write_alarm(DAY_SECOND_WIDTH'(SECONDS_PER_DAY));
            default: write_alarm(alarm_soon());
         endcase
         random_phase <= 1'b1;
         repeat (PHASE_ITEMS)
            send(random_item());
         random_phase <= 1'b0;
      end

      // Run the stopwatch into an alarm armed a few seconds ahead.
      press_until_mode(MODE_STOPWATCH);
      if (!last_display.stopwatch_running)
         press(BUTTON_START);
      settle();
      if (last_display.lap_hold)
         press(BUTTON_LAP);
      press_until_mode(MODE_SET_ALARM);
      if (last_display.alarm_adjust_step != ADJ_NONE)
         press(BUTTON_LAP);
      settle();
      // Toggling the enable on again re-arms an alarm that already fired.
      if (last_display.alarm_enabled)
         press(BUTTON_START);
      press(BUTTON_START);
      write_alarm(alarm_soon());
      repeat (FINAL_TICKS + $urandom_range(0, 20))
         tick();

      settle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

/* digital_watch_mode_controller.f */
sv/dwm_pkg.sv
sv/dwm_front.sv
sv/dwm_cmd_queue.sv
sv/dwm_back.sv
sv/digital_watch_mode_controller.sv
tb/watch_display_checker.sv
tb/tb_top.sv
